### hw/rtl/epm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

  // Default build values
  localparam int unsigned VOICES_DEF      = 8;
  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned REPEATS_DEF     = 4;

  // Field widths fixed by the transaction format
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned VOICE_W   = 3;
  localparam int unsigned GAIN_W    = 7;
  localparam int unsigned DECL_W    = 32;
  localparam int unsigned STORED_W  = 24;
  localparam int unsigned BYTES_W   = 64;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MASK_W    = 8;

  // Accumulator: eight voices of (-128..127) * 127 fit in 18 signed bits
  localparam int unsigned ACC_W     = 18;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int signed   SAMPLE_BIAS  = 128;
  localparam int signed   SUM_MAX      = 32767;
  localparam int signed   SUM_MIN      = -32768;

  // APB register map
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam logic        REG_ENABLE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/epm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command transactions: tick, start voice, stop voice
interface epm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  voice;
  logic [6:0]  volume;
  logic [31:0] declared_length;
  logic [23:0] stored_length;
  logic [63:0] sample_bytes;

  modport source (
    output valid, kind, voice, volume, declared_length, stored_length, sample_bytes,
    input  ready
  );
  modport sink (
    input  valid, kind, voice, volume, declared_length, stored_length, sample_bytes,
    output ready
  );
endinterface

// Mixed frame transactions
interface epm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic               last;
  logic [7:0]         consumed_mask;
  logic [7:0]         playing_mask;

  modport source (
    output valid, mixed_sample, last, consumed_mask, playing_mask,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, last, consumed_mask, playing_mask,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/epm_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module epm_mac import epm_pkg::*; (
  input  wire logic                       clk_i,
  input  wire mac_ctrl_t                  ctrl_i,
  input  wire logic [7:0]                 byte_i,
  input  wire logic [GAIN_W-1:0]          gain_i,
  output logic signed [SAMPLE_W-1:0]      sample_o
);

  logic signed [9:0]       centred;
  logic signed [7:0]       gain_s;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_d, acc_q;

  // Remove the bias and scale by the voice gain
  assign centred = signed'({2'b00, byte_i}) - 10'(SAMPLE_BIAS);
  assign gain_s  = signed'({1'b0, gain_i});
  assign prod    = ACC_W'(centred) * ACC_W'(gain_s);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Saturate the running sum to 16 bits
  always_comb begin
    if (acc_q > ACC_W'(SUM_MAX)) begin
      sample_o = SAMPLE_W'(SUM_MAX);
    end else if (acc_q < ACC_W'(SUM_MIN)) begin
      sample_o = SAMPLE_W'(SUM_MIN);
    end else begin
      sample_o = acc_q[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/epm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module epm_seq import epm_pkg::*; #(
  parameter int unsigned VOICES      = VOICES_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned REPEATS     = REPEATS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   enable_i,
  epm_in_if.sink                      in_i,
  epm_out_if.source                   out_o,
  output mac_ctrl_t                   mac_ctrl_o,
  output logic [7:0]                  mac_byte_o,
  output logic [GAIN_W-1:0]           mac_gain_o,
  input  wire logic signed [SAMPLE_W-1:0] mac_sample_i
);

  localparam int unsigned VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned REP_W  = (REPEATS > 1) ? $clog2(REPEATS) : 1;
  localparam logic [DECL_W:0] LenMax = (33'(1) << LENGTH_BITS) - 33'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_EMIT
  } state_e;

  state_e                  state_d, state_q;
  logic [VIDX_W-1:0]       cnt_d, cnt_q;
  logic [REP_W-1:0]        rep_d, rep_q;
  logic [VOICES-1:0]       active_d, active_q;

  logic [LENGTH_BITS-1:0]  len_q [VOICES];
  logic [LENGTH_BITS-1:0]  pos_q [VOICES];
  logic [GAIN_W-1:0]       gain_q [VOICES];
  logic [BYTES_W-1:0]      bytes_q;
  logic [VOICES-1:0]       consumed_q;

  logic                    in_acc, out_acc, last_rep;
  logic [VIDX_W-1:0]       vsel;
  logic                    vok, start_ok, stop_ok, tick_go, step_use, step_end;
  logic [STORED_W-1:0]     avail;
  logic [DECL_W-1:0]       len_clamp;
  logic [LENGTH_BITS-1:0]  len_fit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign last_rep   = (rep_q == REP_W'(REPEATS - 1));

  // Decode the command transaction
  assign vsel     = in_i.voice[VIDX_W-1:0];
  assign vok      = ({1'b0, in_i.voice} < 4'(VOICES));
  assign start_ok = in_acc && (in_i.kind == KIND_START) && enable_i && vok
                    && (in_i.stored_length > STORED_W'(HEADER_BYTES));
  assign stop_ok  = in_acc && (in_i.kind == KIND_STOP) && vok;
  assign tick_go  = in_acc && (in_i.kind == KIND_TICK) && enable_i;

  // Clamp the declared length to the stored body, then to the counter range
  assign avail     = in_i.stored_length - STORED_W'(HEADER_BYTES);
  assign len_clamp = (in_i.declared_length > DECL_W'(avail)) ? DECL_W'(avail)
                                                            : in_i.declared_length;
  assign len_fit   = ({1'b0, len_clamp} > LenMax) ? LenMax[LENGTH_BITS-1:0]
                                                  : len_clamp[LENGTH_BITS-1:0];

  // One voice per cycle while mixing
  assign step_use = (state_q == ST_MIX) && active_q[cnt_q] && (pos_q[cnt_q] < len_q[cnt_q]);
  assign step_end = (state_q == ST_MIX) && active_q[cnt_q] && !(pos_q[cnt_q] < len_q[cnt_q]);

  assign mac_ctrl_o.clear  = tick_go;
  assign mac_ctrl_o.acc_en = step_use;
  assign mac_byte_o        = bytes_q[7:0];
  assign mac_gain_o        = gain_q[cnt_q];

  // Next state
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rep_d    = rep_q;
    active_d = active_q;
    if (start_ok) begin
      active_d[vsel] = 1'b1;
    end
    if (stop_ok) begin
      active_d[vsel] = 1'b0;
    end
    if (step_end) begin
      active_d[cnt_q] = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (tick_go) begin
          state_d = ST_MIX;
          cnt_d   = '0;
        end
      end
      ST_MIX: begin
        if (cnt_q == VIDX_W'(VOICES - 1)) begin
          state_d = ST_EMIT;
          rep_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_rep) begin
            state_d = ST_IDLE;
          end else begin
            rep_d = rep_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold sequencer state and voice flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rep_q    <= '0;
      active_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rep_q    <= rep_d;
      active_q <= active_d;
    end
  end

  // Voice payload, sample bytes and consumed flags
  always_ff @(posedge clk_i) begin
    if (start_ok) begin
      len_q[vsel]  <= len_fit;
      pos_q[vsel]  <= '0;
      gain_q[vsel] <= in_i.volume;
    end
    if (step_use) begin
      pos_q[cnt_q] <= pos_q[cnt_q] + 1'b1;
    end
    if (tick_go) begin
      bytes_q    <= in_i.sample_bytes;
      consumed_q <= '0;
    end else if (state_q == ST_MIX) begin
      bytes_q <= bytes_q >> 8;
      if (step_use) begin
        consumed_q[cnt_q] <= 1'b1;
      end
    end
  end

  // Present the frame
  assign out_o.valid         = (state_q == ST_EMIT);
  assign out_o.mixed_sample  = mac_sample_i;
  assign out_o.last          = last_rep;
  assign out_o.consumed_mask = MASK_W'(consumed_q);
  assign out_o.playing_mask  = MASK_W'(active_q);

endmodule

`default_nettype wire

### hw/rtl/eight_voice_pcm_mixer_top.sv
// Tick: accepted in an idle cycle; if enabled, the voices are then mixed one per cycle through a
// shared MAC, and REPEATS frames follow, one per cycle while the sink is ready.
// Input is not ready from the tick until the last frame has been taken.
// Start and stop transactions complete in the cycle they are accepted.
// Reset (async, active low) clears enable, all voice playing flags and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module eight_voice_pcm_mixer_top import epm_pkg::*; #(
  parameter int unsigned VOICES      = VOICES_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned REPEATS     = REPEATS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  epm_in_if.sink                 in_i,
  epm_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic                        enable_q;
  logic                        reg_hit;
  mac_ctrl_t                   mac_ctrl;
  logic [7:0]                  mac_byte;
  logic [GAIN_W-1:0]           mac_gain;
  logic signed [SAMPLE_W-1:0]  mac_sample;

  // Register access
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_ENABLE);
  assign prdata  = reg_hit ? DATA_W'(enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      enable_q <= pwdata[0];
    end
  end

  epm_seq #(
    .VOICES      (VOICES),
    .LENGTH_BITS (LENGTH_BITS),
    .REPEATS     (REPEATS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .in_i         (in_i),
    .out_o        (out_o),
    .mac_ctrl_o   (mac_ctrl),
    .mac_byte_o   (mac_byte),
    .mac_gain_o   (mac_gain),
    .mac_sample_i (mac_sample)
  );

  epm_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .byte_i   (mac_byte),
    .gain_i   (mac_gain),
    .sample_o (mac_sample)
  );

endmodule

`default_nettype wire
